// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Implication from a trigger to a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons) \
    `ASSERT_CLK(label, clk, rst_n, (trig) |-> (cons))

// Implication from a trigger to a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    `ASSERT_CLK(label, clk, rst_n, (trig) |=> (cons))

`endif

// ===== src/ppi_pkg.sv =====
package ppi_pkg;

    typedef struct packed {
        logic       first_pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] color_index;
        logic       newly_added;
        logic       palette_full_overflow;
        logic [8:0] distinct_count;
    } t_pix_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_HIT,
        ST_MISS
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic ptr_inc;
        logic hit;
        logic miss;
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;
        logic match;
        logic last;
    } t_dp_status;

endpackage

// ===== src/ppi_ram.sv =====
module ppi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ppi_ctrl.sv =====
module ppi_ctrl import ppi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = i_status.empty ? ST_MISS : ST_CMP;
            end
            ST_CMP: begin
                if (i_status.match) begin
                    n_state = ST_HIT;
                end else if (i_status.last) begin
                    n_state = ST_MISS;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_HIT:  n_state = ST_IDLE;
            ST_MISS: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_READ: begin
                o_cmd.rd_en = !i_status.empty;
            end
            ST_CMP: begin
                o_cmd.ptr_inc = !i_status.match && !i_status.last;
            end
            ST_HIT: begin
                o_cmd.hit = 1'b1;
            end
            ST_MISS: begin
                o_cmd.miss = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/ppi_datapath.sv =====
module ppi_datapath import ppi_pkg::*; #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pix_in    i_pixel,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    output logic       o_valid,
    output t_pix_out   o_result
);

    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(PALETTE_SIZE);

    logic [23:0]      r_color;
    logic [IDX_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_valid;
    t_pix_out         r_result;

    logic [23:0]      ram_rdata;
    logic             full;
    logic             ram_we;
    logic [CNT_W-1:0] count_inc;

    assign full      = (r_count == FULL_CNT);
    assign ram_we    = i_cmd.miss && !full;
    assign count_inc = r_count + CNT_W'(1);

    ppi_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_color),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_status.empty = (r_count == '0);
    assign o_status.match = (ram_rdata == r_color);
    assign o_status.last  = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.hit || i_cmd.miss;
            if (i_cmd.load && i_pixel.first_pixel) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.miss) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_color <= {i_pixel.red, i_pixel.green, i_pixel.blue};
            r_ptr   <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (i_cmd.hit) begin
            r_result.color_index           <= 8'(r_ptr);
            r_result.newly_added           <= 1'b0;
            r_result.palette_full_overflow <= r_ovf;
            r_result.distinct_count        <= 9'(r_count);
        end else if (i_cmd.miss) begin
            if (full) begin
                r_result.color_index           <= 8'd0;
                r_result.newly_added           <= 1'b0;
                r_result.palette_full_overflow <= 1'b1;
                r_result.distinct_count        <= 9'(r_count);
            end else begin
                r_result.color_index           <= 8'(r_count);
                r_result.newly_added           <= 1'b1;
                r_result.palette_full_overflow <= r_ovf;
                r_result.distinct_count        <= 9'(count_inc);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/pixel_palette_indexer.sv =====
// Builds a palette of distinct RGB colors in order of first appearance and returns
// the palette index of each pixel, or index 0 with the overflow flag when a new color
// finds the palette full. A request is taken when i_start is high and o_busy is low;
// its result appears on o_result for exactly one cycle with o_valid high, and the
// receiver cannot stall it, so it must capture every strobe. The palette lives in a
// single-port-read RAM that is scanned one entry at a time, each entry read and then
// compared, until a match or the last entry (an empty palette skips the scan);
// o_busy falls in the cycle the result is shown, and the next request may be taken
// then.
module pixel_palette_indexer import ppi_pkg::*; #(
    parameter int PALETTE_SIZE = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_pix_in  i_pixel,
    output logic     o_busy,
    output logic     o_valid,
    output t_pix_out o_result
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ppi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    ppi_datapath #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (i_pixel),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== src/ppi_checker.sv =====
`include "assert_macros.svh"

module ppi_checker import ppi_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input logic     o_valid,
    input t_pix_out o_result
);

    logic added;

    assign added = o_valid && o_result.newly_added;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_IMPLIES(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(o_busy))
    `ASSERT_IMPLIES(a_added_no_ovf, i_clk, i_rst_n, added, !o_result.palette_full_overflow)

endmodule

bind pixel_palette_indexer ppi_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
